// ===== rtl/brc_pkg.sv =====
// shared types and constants for the bit realigning copy block
package brc_pkg;

    localparam int BYTE_BITS      = 8;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 3;
    localparam int COPIED_W       = 24;
    localparam int COUNT_BITS_DEF = 24;
    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SRC_OFFSET      = 3'd0,
        CFG_DST_OFFSET      = 3'd1,
        CFG_REQUEST_BITS    = 3'd2,
        CFG_SRC_LENGTH_BITS = 3'd3,
        CFG_DST_LENGTH_BITS = 3'd4,
        CFG_HEAD_BYTE       = 3'd5,
        CFG_TAIL_BYTE       = 3'd6
    } cfg_idx_t;

    // one or two destination bytes caused by one source byte
    typedef struct packed {
        logic [BYTE_BITS-1:0] byte0;
        logic                 fin0;
        logic [BYTE_BITS-1:0] byte1;
        logic                 two;
        logic [COPIED_W-1:0]  copied;
    } grp_t;

endpackage

// ===== rtl/bit_granular_realign_copy.sv =====
// top level of the bit realigning copy block
// Copies a bit run MSB first from a stream of source bytes into destination
// bytes, moving it from src_offset to dst_offset within the byte. The run
// length is the smallest of request_bits, src_length_bits, dst_length_bits.
// Registers are written through cfg_we / cfg_index / cfg_data with the block
// idle; every write re-arms the transfer, and the next source byte starts it.
// Source bytes arrive on in_valid / in_ready / src_byte; destination bytes
// leave on out_valid / out_ready with final_flag and copied_count on the last.
// Throughput: one source byte per cycle while the group queue has room; the last source byte may yield two
// destination bytes, which leave one after the other.
// A destination byte is offered from the output register: the edge that takes its source byte writes
// the group queue, and the output register loads that group once it is free.
// A four-entry group queue parts the shifter from the output register, so the
// source side keeps flowing while the receiver stalls until the queue fills,
// then in_ready drops. Reset arms a transfer and zeroes all but the data storage registers.
module bit_granular_realign_copy #(
    parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [brc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [brc_pkg::BYTE_BITS-1:0]   src_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [brc_pkg::BYTE_BITS-1:0]   dst_data,
    output logic                            final_flag,
    output logic [brc_pkg::COPIED_W-1:0]    copied_count
);

    logic          push, full, pop, head_valid;
    brc_pkg::grp_t push_grp, head_grp;

    brc_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .src_byte (src_byte),
        .fifo_full(full),
        .push     (push),
        .push_grp (push_grp)
    );

    brc_fifo #(
        .DEPTH(brc_pkg::FIFO_DEPTH_DEF)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_grp  (push_grp),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_grp  (head_grp)
    );

    brc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_grp    (head_grp),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .dst_data    (dst_data),
        .final_flag  (final_flag),
        .copied_count(copied_count)
    );

endmodule

// ===== rtl/brc_front.sv =====
// front end: configuration registers, realigning shifter and group builder
module brc_front #(
    parameter int COUNT_BITS = brc_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [brc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [brc_pkg::BYTE_BITS-1:0]      src_byte,
    input  logic                               fifo_full,
    output logic                               push,
    output brc_pkg::grp_t                      push_grp
);

    localparam int XW = (COUNT_BITS > 24) ? COUNT_BITS : 24;

    logic [2:0]            soff_reg, doff_reg;
    logic [23:0]           req_reg, slen_reg, dlen_reg;
    logic [7:0]            head_reg, tail_reg;
    logic [6:0]            pend_reg;
    logic [2:0]            cnt_reg;
    logic [COUNT_BITS-1:0] left_reg;
    logic                  first_reg;

    logic [23:0]           n_a, n24;
    logic [XW-1:0]         nx;
    logic [COUNT_BITS-1:0] total, left, left_n;
    logic [3:0]            room, skip_n, avail, take, cnt, cnt2, keep_n;
    logic [7:0]            head_lead, shifted, chunk, byte0, tail_out, keep_src;
    logic [6:0]            base_bits, acc2;
    logic [2:0]            base_cnt;
    logic [14:0]           acc;
    logic                  active, short_run, emit1, emit_tail, fin0, accept;

    function automatic logic [brc_pkg::COPIED_W-1:0] COPIED_W_CAST(
        input logic [COUNT_BITS-1:0] v
    );
        logic [XW-1:0] w;
        w = XW'(v);
        return w[brc_pkg::COPIED_W-1:0];
    endfunction

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    // run length: smallest of the three counts, saturated to the counter width
    always_comb
    begin
        n_a   = (slen_reg < req_reg) ? slen_reg : req_reg;
        n24   = (dlen_reg < n_a) ? dlen_reg : n_a;
        nx    = XW'(n24);
        total = (nx > XW'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}} : nx[COUNT_BITS-1:0];
    end

    always_comb
    begin
        room      = 4'd8 - {1'b0, doff_reg};
        short_run = (total <= COUNT_BITS'(room));
        head_lead = head_reg >> room;
        base_bits = first_reg ? head_lead[6:0] : pend_reg;
        base_cnt  = first_reg ? doff_reg : cnt_reg;
        left      = first_reg ? total : left_reg;
        active    = (left != '0);
        skip_n    = first_reg ? {1'b0, soff_reg} : 4'd0;
        avail     = 4'd8 - skip_n;
        take      = (left < COUNT_BITS'(avail)) ? left[3:0] : avail;
        shifted   = src_byte >> (avail - take);
        chunk     = shifted & 8'((9'd1 << take) - 9'd1);
        acc       = (15'(base_bits) << take) | 15'(chunk);
        cnt       = {1'b0, base_cnt} + take;
        left_n    = left - COUNT_BITS'(take);
        emit1     = (cnt >= 4'd8);
        byte0     = 8'(acc >> (cnt - 4'd8));
        cnt2      = emit1 ? (cnt - 4'd8) : cnt;
        acc2      = acc[6:0] & 7'((8'd1 << cnt2[2:0]) - 8'd1);
        fin0      = (left_n == '0) && (cnt2 == 4'd0);
        emit_tail = (left_n == '0) && (cnt2 != 4'd0);
        keep_n    = 4'd8 - cnt2;
        keep_src  = short_run ? head_reg : tail_reg;
        tail_out  = (8'(acc2) << keep_n) | (keep_src & 8'((9'd1 << keep_n) - 9'd1));
    end

    always_comb
    begin
        push_grp.copied = COPIED_W_CAST(total);
        if (emit1)
        begin
            push_grp.byte0 = byte0;
            push_grp.fin0  = fin0;
            push_grp.byte1 = tail_out;
            push_grp.two   = emit_tail;
        end
        else
        begin
            push_grp.byte0 = tail_out;
            push_grp.fin0  = 1'b1;
            push_grp.byte1 = tail_out;
            push_grp.two   = 1'b0;
        end
        push = accept && active && (emit1 || emit_tail);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soff_reg  <= '0;
            doff_reg  <= '0;
            req_reg   <= '0;
            slen_reg  <= '0;
            dlen_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                brc_pkg::CFG_SRC_OFFSET:      soff_reg <= cfg_data[2:0];
                brc_pkg::CFG_DST_OFFSET:      doff_reg <= cfg_data[2:0];
                brc_pkg::CFG_REQUEST_BITS:    req_reg  <= cfg_data;
                brc_pkg::CFG_SRC_LENGTH_BITS: slen_reg <= cfg_data;
                brc_pkg::CFG_DST_LENGTH_BITS: dlen_reg <= cfg_data;
                brc_pkg::CFG_HEAD_BYTE:       head_reg <= cfg_data[7:0];
                brc_pkg::CFG_TAIL_BYTE:       tail_reg <= cfg_data[7:0];
                default:                      ;
            endcase
            // any write re-arms the transfer
            pend_reg  <= '0;
            cnt_reg   <= '0;
            left_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            first_reg <= 1'b0;
            if (active)
            begin
                left_reg <= left_n;
                pend_reg <= emit_tail ? 7'd0 : acc2;
                cnt_reg  <= emit_tail ? 3'd0 : cnt2[2:0];
            end
        end
    end

endmodule

// ===== rtl/brc_fifo.sv =====
// small group queue between the front end and the output stage
module brc_fifo #(
    parameter int DEPTH = brc_pkg::FIFO_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  brc_pkg::grp_t push_grp,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output brc_pkg::grp_t head_grp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    brc_pkg::grp_t   mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_grp   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("group queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("group queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("group queue count out of range");

endmodule

// ===== rtl/brc_back.sv =====
// output stage: walks each group out one destination byte per request
module brc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  brc_pkg::grp_t                 head_grp,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [brc_pkg::BYTE_BITS-1:0] dst_data,
    output logic                          final_flag,
    output logic [brc_pkg::COPIED_W-1:0]  copied_count
);

    brc_pkg::grp_t grp_reg;
    logic          valid_reg;
    logic          idx_reg;
    logic          out_acc, last;

    assign out_acc      = valid_reg && out_ready;
    assign last         = !grp_reg.two || idx_reg;
    assign pop          = head_valid && (!valid_reg || (out_acc && last));
    assign out_valid    = valid_reg;
    assign dst_data     = idx_reg ? grp_reg.byte1 : grp_reg.byte0;
    assign final_flag   = idx_reg ? 1'b1 : grp_reg.fin0;
    assign copied_count = final_flag ? grp_reg.copied : '0;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            grp_reg <= head_grp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= 1'b0;
        end
        else if (out_acc)
        begin
            // second byte of a pair follows, otherwise the stage empties
            valid_reg <= !last;
            idx_reg   <= !last;
        end
    end

endmodule

// ===== sim/bit_granular_realign_copy_tb.sv =====
// testbench for bit_granular_realign_copy: random realigning copies checked against a predictor
`timescale 1ns / 100ps

module bit_granular_realign_copy_tb;

    typedef logic [brc_pkg::CFG_DATA_W-1:0] cfg_word_t;

    // index outside the register list, a write there only re-arms the transfer
    localparam logic [brc_pkg::CFG_INDEX_W-1:0] CFG_NONE = 3'd7;
    localparam int TOTAL_ITEMS = 1700;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [brc_pkg::BYTE_BITS-1:0] data;
        logic                          fin;
        logic [brc_pkg::COPIED_W-1:0]  copied;
    } dest_t;

    class realign_board;
        dest_t       due[$];
        int          errors;
        logic [2:0]  src_off;
        logic [2:0]  dst_off;
        cfg_word_t   req_bits;
        cfg_word_t   src_len;
        cfg_word_t   dst_len;
        logic [7:0]  head;
        logic [7:0]  tail;
        int unsigned pend;
        int unsigned pcnt;
        int unsigned src_left;
        bit          armed;

        function new();
            errors = 0;
            src_off = 0;
            dst_off = 0;
            req_bits = 0;
            src_len = 0;
            dst_len = 0;
            head = 0;
            tail = 0;
            rearm();
        endfunction

        function void rearm();
            pend = 0;
            pcnt = 0;
            src_left = 0;
            armed = 1'b1;
        endfunction

        function void write_reg(logic [brc_pkg::CFG_INDEX_W-1:0] idx, cfg_word_t data);
            case (idx)
                brc_pkg::CFG_SRC_OFFSET:      src_off = data[2:0];
                brc_pkg::CFG_DST_OFFSET:      dst_off = data[2:0];
                brc_pkg::CFG_REQUEST_BITS:    req_bits = data;
                brc_pkg::CFG_SRC_LENGTH_BITS: src_len = data;
                brc_pkg::CFG_DST_LENGTH_BITS: dst_len = data;
                brc_pkg::CFG_HEAD_BYTE:       head = data[7:0];
                brc_pkg::CFG_TAIL_BYTE:       tail = data[7:0];
                default: ;
            endcase
            rearm();
        endfunction

        // counts are 24 bits wide, so the minimum never needs saturating
        function int unsigned run_len();
            int unsigned n;
            n = 32'(req_bits);
            if (32'(src_len) < n) n = 32'(src_len);
            if (32'(dst_len) < n) n = 32'(dst_len);
            return n;
        endfunction

        function int unsigned needed_bytes();
            int unsigned n;
            n = run_len();
            return (n == 0) ? 0 : (32'(src_off) + n + 7) / 8;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void take_source(logic [7:0] b);
            int unsigned skip;
            int unsigned dofs;
            int unsigned total;
            int unsigned avail;
            int unsigned take;
            int unsigned chunk;
            int unsigned keep_n;
            int unsigned keep_mask;
            int unsigned keep_byte;
            int unsigned bv;
            dest_t d;
            skip = 0;
            dofs = 32'(dst_off);
            total = run_len();
            bv = 32'(b);
            if (armed)
            begin
                armed = 1'b0;
                src_left = total;
                pend = 0;
                pcnt = 0;
                if (total == 0)
                    return;
                // leading bits of the first destination byte are kept
                pend = (32'(head) >> (8 - dofs)) & ((1 << dofs) - 1);
                pcnt = dofs;
                skip = 32'(src_off);
            end
            else if (src_left == 0)
            begin
                return;
            end
            avail = 8 - skip;
            take = (avail > src_left) ? src_left : avail;
            chunk = (bv >> (avail - take)) & ((1 << take) - 1);
            pend = ((pend << take) | chunk) & 16'hFFFF;
            pcnt += take;
            src_left -= take;
            if (pcnt >= 8)
            begin
                d.data = 8'(pend >> (pcnt - 8));
                pcnt -= 8;
                pend &= (1 << pcnt) - 1;
                d.fin = (src_left == 0) && (pcnt == 0);
                d.copied = d.fin ? total[brc_pkg::COPIED_W-1:0] : '0;
                due.push_back(d);
            end
            if (src_left == 0 && pcnt > 0)
            begin
                keep_n = 8 - pcnt;
                keep_mask = (1 << keep_n) - 1;
                // a run ending inside the first byte keeps head bits on both sides
                keep_byte = (dofs + total <= 8) ? 32'(head) : 32'(tail);
                d.data = 8'(((pend << keep_n) & 8'hFF) | (keep_byte & keep_mask));
                d.fin = 1'b1;
                d.copied = total[brc_pkg::COPIED_W-1:0];
                pend = 0;
                pcnt = 0;
                due.push_back(d);
            end
        endfunction

        function void check_dest(logic [7:0] data, logic fin,
                                 logic [brc_pkg::COPIED_W-1:0] copied);
            dest_t d;
            if (due.size() == 0)
            begin
                $error("dst_data %h arrived with no request pending", data);
                errors++;
                return;
            end
            d = due.pop_front();
            if (data !== d.data)
            begin
                $error("dst_data: expected %h, got %h", d.data, data);
                errors++;
            end
            if (fin !== d.fin)
            begin
                $error("final_flag: expected %b, got %b", d.fin, fin);
                errors++;
            end
            if (copied !== d.copied)
            begin
                $error("copied_count: expected %0d, got %0d", d.copied, copied);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [brc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    cfg_word_t                       cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [brc_pkg::BYTE_BITS-1:0]   src_byte = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [brc_pkg::BYTE_BITS-1:0]   dst_data;
    logic                            final_flag;
    logic [brc_pkg::COPIED_W-1:0]    copied_count;

    realign_board board;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;

    bit_granular_realign_copy i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .src_byte     (src_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dst_data     (dst_data),
        .final_flag   (final_flag),
        .copied_count (copied_count)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1600000;
        $display("bit_granular_realign_copy test failed");
        $finish;
    end

    // receiving side, with a long hold-off on demand
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_dest(dst_data, final_flag, copied_count);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(logic [brc_pkg::CFG_INDEX_W-1:0] idx, cfg_word_t data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_config(cfg_word_t so, cfg_word_t dof, cfg_word_t req, cfg_word_t sl,
                              cfg_word_t dl, cfg_word_t hd, cfg_word_t tl);
        write_reg(brc_pkg::CFG_SRC_OFFSET, so);
        write_reg(brc_pkg::CFG_DST_OFFSET, dof);
        write_reg(brc_pkg::CFG_REQUEST_BITS, req);
        write_reg(brc_pkg::CFG_SRC_LENGTH_BITS, sl);
        write_reg(brc_pkg::CFG_DST_LENGTH_BITS, dl);
        write_reg(brc_pkg::CFG_HEAD_BYTE, hd);
        write_reg(brc_pkg::CFG_TAIL_BYTE, tl);
        cfg_we <= 1'b0;
    endtask

    task automatic rearm_only();
        write_reg(CFG_NONE, cfg_word_t'($urandom_range(0, 24'hFFFFFF)));
        cfg_we <= 1'b0;
    endtask

    task automatic send_source(int count);
        logic [7:0] v;
        for (int i = 0; i < count; i++)
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            v = 8'($urandom_range(0, 255));
            in_valid <= 1'b1;
            src_byte <= v;
            do @(posedge clk); while (!in_ready);
            board.take_source(v);
            items_sent++;
        end
        in_valid <= 1'b0;
    endtask

    // block idle: all results in, and bytes that give none have passed through
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_transfer();
        int unsigned len;
        int unsigned pick;
        int unsigned which;
        int unsigned n;
        cfg_word_t lens[3];
        settle();
        if ($urandom_range(0, 9) == 0)
        begin
            rearm_only();
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                len = 0;
            else if (pick < 85)
                len = $urandom_range(1, 40);
            else if (pick < 97)
                len = $urandom_range(41, 300);
            else
                len = $urandom_range(301, 1200);
            which = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                if (k == which)
                    lens[k] = cfg_word_t'(len);
                else if ($urandom_range(0, 3) == 0)
                    lens[k] = 24'hFFFFFF;
                else
                    lens[k] = cfg_word_t'(len + $urandom_range(0, 64));
            end
            set_config({21'($urandom_range(0, 21'h1FFFFF)), 3'($urandom_range(0, 7))},
                       {21'($urandom_range(0, 21'h1FFFFF)), 3'($urandom_range(0, 7))},
                       lens[0], lens[1], lens[2],
                       {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255))},
                       {16'($urandom_range(0, 16'hFFFF)), 8'($urandom_range(0, 255))});
        end
        n = board.needed_bytes();
        if (n == 0)
            n = $urandom_range(1, 3);
        else if ($urandom_range(0, 2) == 0)
            n += $urandom_range(1, 2);
        send_source(n);
    endtask

    initial
    begin
        int phase;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty run straight after reset
        send_source(2);
        settle();
        // short aligned run inside one byte
        set_config(3, 3, 2, 2, 2, 8'hA5, 8'h3C);
        send_source(1);
        settle();
        set_config(7, 0, 1, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'h00);
        send_source(2);
        settle();
        // unaligned run ending inside the first byte
        set_config(1, 5, 3, 3, 9, 8'h5A, 8'hC3);
        send_source(1);
        settle();
        set_config(0, 0, 8, 8, 8, 8'h00, 8'hFF);
        send_source(2);
        settle();
        // last source byte yields two destination bytes
        set_config(0, 7, 15, 15, 15, 8'h81, 8'h7E);
        send_source(2);
        settle();
        // offsets written with all data bits set
        set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 20, 24'hFFFFFF, 24'h0);
        send_source(4);
        settle();
        // destination length zero gives an empty run
        set_config(2, 6, 19, 24'hFFFFFF, 0, 8'hC3, 8'h3C);
        send_source(2);
        settle();
        set_config(5, 2, 40, 22, 35, 8'h96, 8'h69);
        send_source(4);
        settle();
        rearm_only();
        send_source(4);

        // long receiver hold-off so the block fills and stalls its input
        settle();
        set_config(0, 3, 480, 480, 480, 8'h0F, 8'hF0);
        hold_left = 100;
        send_source(board.needed_bytes());

        while (items_sent < TOTAL_ITEMS)
        begin
            phase = items_sent * 4 / TOTAL_ITEMS;
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 62;
                end
                default:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            random_transfer();
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("bit_granular_realign_copy test passed");
        else
            $display("bit_granular_realign_copy test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/brc_pkg.sv
rtl/brc_front.sv
rtl/brc_fifo.sv
rtl/brc_back.sv
rtl/bit_granular_realign_copy.sv
sim/bit_granular_realign_copy_tb.sv
